[sv/pssc_pkg.sv]
// ----------------------------------------------------------------------------
// pssc_pkg
// Shared constants and types for the port scan source classifier.
// ----------------------------------------------------------------------------
package pssc_pkg;

  localparam int MaxSources    = 32;
  localparam int MaxPorts      = 64;
  localparam int SrcIdxW       = $clog2(MaxSources);
  localparam int SrcCntW       = $clog2(MaxSources + 1);
  localparam int PortIdxW      = $clog2(MaxPorts);
  localparam int PortCntW      = $clog2(MaxPorts + 1);
  localparam int PortAddrW     = SrcIdxW + PortIdxW;
  localparam int ThrW          = 7;

  typedef enum logic [2:0] {
    KIND_NEW_SOURCE  = 3'd0,
    KIND_NEW_PORT    = 3'd1,
    KIND_REPEAT      = 3'd2,
    KIND_TABLE_FULL  = 3'd3,
    KIND_PORTS_FULL  = 3'd4,
    KIND_REPORT      = 3'd5,
    KIND_EMPTY       = 3'd6
  } kind_t;

  localparam logic [1:0] VERDICT_NONE     = 2'd0;
  localparam logic [1:0] VERDICT_POSSIBLE = 2'd1;
  localparam logic [1:0] VERDICT_LIKELY   = 2'd2;

  localparam logic ACTION_RECORD = 1'b0;
  localparam logic ACTION_REPORT = 1'b1;

  localparam logic CFG_LIKELY   = 1'b0;
  localparam logic CFG_POSSIBLE = 1'b1;

  // classify a count against both thresholds
  function automatic logic [1:0] classify(input logic [6:0] cnt,
                                          input logic [ThrW-1:0] likely,
                                          input logic [ThrW-1:0] possible);
    logic [1:0] v;
    if (cnt >= likely) v = VERDICT_LIKELY;
    else if (cnt >= possible) v = VERDICT_POSSIBLE;
    else v = VERDICT_NONE;
    return v;
  endfunction

endpackage

[sv/port_scan_source_classifier_core.sv]
// ----------------------------------------------------------------------------
// port_scan_source_classifier_core
// Tracks distinct destination ports per source and reports scan verdicts.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                     Payload
// s_axis    in   tvalid/tready/tdata[55:0]   action, source_addr, dest_port
// m_axis    out  tvalid/tready/tdata/tuser   source_out, distinct_ports,
//                tlast                       verdict / kind / last
// cfg       in   cfg_we/cfg_index/cfg_data   likely, possible threshold
//
// A record scans the source table (per entry a read state, then a compare
// state, up to sources_used entries) and then the port slice of the matching
// source (a read and a compare state per stored port), and then waits in
// ST_OUT until its result is accepted, so any output stall holds it.
// A report reads one stored source at a time, waiting for the output register.
// rst is synchronous; it clears sources_used and the control state, and it
// sets the likely and possible thresholds to 20 and 10. The memories have
// no reset. A stalled result holds; no item is taken until the pending result
// has been accepted.
// ----------------------------------------------------------------------------
module port_scan_source_classifier_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action[0], source_addr[32:1], dest_port[48:33], zero fill
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // source_out[31:0], distinct_ports[38:32], verdict[40:39], zero fill
  output logic [47:0] m_axis_tdata,
  // kind[2:0]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int SW = pssc_pkg::SrcIdxW;
  localparam int SC = pssc_pkg::SrcCntW;
  localparam int PW = pssc_pkg::PortIdxW;
  localparam int PC = pssc_pkg::PortCntW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SRC_RD, ST_SRC_CMP, ST_PRT_RD, ST_PRT_CMP,
    ST_REP_RD, ST_REP_OUT, ST_OUT
  } state_t;

  state_t state;

  logic [6:0] likely_thr, possible_thr;
  logic [SC-1:0] sources_used;

  // memories: source entry holds {port count, address}
  logic [PC+31:0]         src_mem [pssc_pkg::MaxSources];
  logic [15:0]            prt_mem [pssc_pkg::MaxSources * pssc_pkg::MaxPorts];
  logic [31:0]            src_rd;
  logic [PC-1:0]          cnt_rd;
  logic [15:0]            prt_rd;
  logic [SW-1:0]          src_addr;
  logic [pssc_pkg::PortAddrW-1:0] prt_addr;
  logic                   src_we, prt_we;
  logic [31:0]            src_wd;
  logic [PC-1:0]          cnt_wd;
  logic [15:0]            prt_wd;

  // item registers
  logic [31:0]   src;
  logic [15:0]   port;
  logic [SC-1:0] si;
  logic [PC-1:0] pk;
  logic [PC-1:0] cnt;
  logic          last_rep;

  // registered write requests
  logic          wr_src, wr_prt;
  logic [SW-1:0] wr_si;
  logic [PW-1:0] wr_pk;
  logic [PC-1:0] wr_cnt;

  logic [6:0] cnt7;
  assign cnt7 = 7'(cnt_rd);

  // read/write the memories
  always_ff @(posedge clk) begin
    if (src_we) src_mem[src_addr] <= {cnt_wd, src_wd};
    if (prt_we) prt_mem[prt_addr] <= prt_wd;
    {cnt_rd, src_rd} <= src_mem[src_addr];
    prt_rd <= prt_mem[prt_addr];
  end

  // address and write control
  always_comb begin
    src_we   = wr_src;
    prt_we   = wr_prt;
    src_wd   = src;
    cnt_wd   = wr_cnt;
    prt_wd   = port;
    src_addr = si[SW-1:0];
    prt_addr = {si[SW-1:0], pk[PW-1:0]};
    // writes are issued from registered flags
    if (wr_src || wr_prt) begin
      src_addr = wr_si;
      prt_addr = {wr_si, wr_pk};
    end
  end

  assign s_axis_tready = (state == ST_IDLE) && !m_axis_tvalid;

  logic [1:0] vd_rd;
  assign vd_rd = pssc_pkg::classify(cnt7, likely_thr, possible_thr);

  assign last_rep = (si + SC'(1) == sources_used);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      sources_used <= '0;
      likely_thr   <= 7'd20;
      possible_thr <= 7'd10;
      wr_src       <= 1'b0;
      wr_prt       <= 1'b0;
    end else begin
      wr_src <= 1'b0;
      wr_prt <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == pssc_pkg::CFG_LIKELY) likely_thr <= cfg_data;
        else possible_thr <= cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            src  <= s_axis_tdata[32:1];
            port <= s_axis_tdata[48:33];
            si   <= '0;
            if (s_axis_tdata[0] == pssc_pkg::ACTION_REPORT) begin
              if (sources_used == '0) begin
                m_axis_tdata  <= '0;
                m_axis_tuser  <= pssc_pkg::KIND_EMPTY;
                m_axis_tlast  <= 1'b1;
                m_axis_tvalid <= 1'b1;
              end else begin
                state <= ST_REP_RD;
              end
            end else begin
              state <= ST_SRC_RD;
            end
          end
        end
        // compare one source per read
        ST_SRC_RD: begin
          if (si < sources_used) state <= ST_SRC_CMP;
          else if (sources_used < SC'(pssc_pkg::MaxSources)) begin
            wr_src <= 1'b1;
            wr_prt <= 1'b1;
            wr_si  <= si[SW-1:0];
            wr_pk  <= '0;
            wr_cnt <= PC'(1);
            sources_used <= sources_used + SC'(1);
            m_axis_tdata  <= 48'({pssc_pkg::classify(7'd1, likely_thr, possible_thr),
                                  7'd1, src});
            m_axis_tuser  <= pssc_pkg::KIND_NEW_SOURCE;
            m_axis_tlast  <= 1'b1;
            m_axis_tvalid <= 1'b1;
            state <= ST_OUT;
          end else begin
            m_axis_tdata  <= 48'(src);
            m_axis_tuser  <= pssc_pkg::KIND_TABLE_FULL;
            m_axis_tlast  <= 1'b1;
            m_axis_tvalid <= 1'b1;
            state <= ST_OUT;
          end
        end
        ST_SRC_CMP: begin
          if (src_rd == src) begin
            cnt   <= cnt_rd;
            pk    <= '0;
            state <= ST_PRT_RD;
          end else begin
            si    <= si + SC'(1);
            state <= ST_SRC_RD;
          end
        end
        // compare one port per read
        ST_PRT_RD: begin
          if (pk < cnt) state <= ST_PRT_CMP;
          else if (cnt < PC'(pssc_pkg::MaxPorts)) begin
            wr_src <= 1'b1;
            wr_prt <= 1'b1;
            wr_si  <= si[SW-1:0];
            wr_pk  <= cnt[PW-1:0];
            wr_cnt <= cnt + PC'(1);
            m_axis_tdata  <= 48'({pssc_pkg::classify(7'(cnt + PC'(1)), likely_thr,
                                  possible_thr), 7'(cnt + PC'(1)), src});
            m_axis_tuser  <= pssc_pkg::KIND_NEW_PORT;
            m_axis_tlast  <= 1'b1;
            m_axis_tvalid <= 1'b1;
            state <= ST_OUT;
          end else begin
            m_axis_tdata  <= 48'({pssc_pkg::classify(7'(cnt), likely_thr,
                                  possible_thr), 7'(cnt), src});
            m_axis_tuser  <= pssc_pkg::KIND_PORTS_FULL;
            m_axis_tlast  <= 1'b1;
            m_axis_tvalid <= 1'b1;
            state <= ST_OUT;
          end
        end
        ST_PRT_CMP: begin
          if (prt_rd == port) begin
            m_axis_tdata  <= 48'({pssc_pkg::classify(7'(cnt), likely_thr,
                                  possible_thr), 7'(cnt), src});
            m_axis_tuser  <= pssc_pkg::KIND_REPEAT;
            m_axis_tlast  <= 1'b1;
            m_axis_tvalid <= 1'b1;
            state <= ST_OUT;
          end else begin
            pk    <= pk + PC'(1);
            state <= ST_PRT_RD;
          end
        end
        // report: wait for the output register, then read one source
        ST_REP_RD: begin
          if (!m_axis_tvalid || m_axis_tready) state <= ST_REP_OUT;
        end
        ST_REP_OUT: begin
          m_axis_tdata  <= 48'({vd_rd, cnt7, src_rd});
          m_axis_tuser  <= pssc_pkg::KIND_REPORT;
          m_axis_tlast  <= last_rep;
          m_axis_tvalid <= 1'b1;
          si    <= si + SC'(1);
          state <= last_rep ? ST_OUT : ST_REP_RD;
        end
        ST_OUT: begin
          if (m_axis_tvalid && m_axis_tready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a result never appears while a new item is being accepted
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("ready while result pending");
  // source count never exceeds the table depth
  assert property (@(posedge clk) disable iff (rst)
    sources_used <= SC'(pssc_pkg::MaxSources))
    else $error("source count overflow");
  // a stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed under stall");
`endif

endmodule

[bench/port_scan_source_classifier_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// port_scan_source_classifier_core_tb
// Drives connection records, report requests and threshold writes into the
// classifier, keeps its own copy of the source table and port sets, and checks
// every result item against the predicted kind, source, count, verdict and last.
// ----------------------------------------------------------------------------
module port_scan_source_classifier_core_tb;

  localparam int TotalItems = 360;
  localparam int PoolSize   = 40;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] src;
    logic [6:0]  cnt;
    logic [1:0]  verdict;
    logic        last;
  } scan_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // action[0], source_addr[32:1], dest_port[48:33], zero fill
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // source_out[31:0], distinct_ports[38:32], verdict[40:39], zero fill
  logic [47:0] m_axis_tdata;
  // kind[2:0]
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we;
  logic        cfg_index;
  logic [6:0]  cfg_data;

  port_scan_source_classifier_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // predictor state
  logic [6:0]  thr_likely;
  logic [6:0]  thr_possible;
  logic [31:0] known_src [pssc_pkg::MaxSources];
  logic [15:0] known_port [pssc_pkg::MaxSources][pssc_pkg::MaxPorts];
  int          port_total [pssc_pkg::MaxSources];
  int          src_total;

  logic [31:0]  addr_pool [PoolSize];
  scan_result_t pending_results [$];
  scan_result_t got;
  scan_result_t want;
  int           mismatch_count;
  int           items_sent;
  bit           tail_phase;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

  // verdict for a count under the current thresholds
  function automatic logic [1:0] predict_verdict(input int c);
    logic [1:0] v;
    if (c >= int'(thr_likely)) v = pssc_pkg::VERDICT_LIKELY;
    else if (c >= int'(thr_possible)) v = pssc_pkg::VERDICT_POSSIBLE;
    else v = pssc_pkg::VERDICT_NONE;
    return v;
  endfunction

  function automatic scan_result_t make_result(input logic [2:0] k, input logic [31:0] a,
                                               input int c, input logic [1:0] v,
                                               input logic l);
    scan_result_t r;
    r.kind    = k;
    r.src     = a;
    r.cnt     = 7'(c);
    r.verdict = v;
    r.last    = l;
    return r;
  endfunction

  // predict the results of one accepted item
  task automatic predict(input logic act, input logic [31:0] a, input logic [15:0] p);
    int  i;
    int  k;
    int  hit;
    bit  found;
    hit   = -1;
    found = 1'b0;
    if (act == pssc_pkg::ACTION_REPORT) begin
      if (src_total == 0) begin
        pending_results.push_back(make_result(pssc_pkg::KIND_EMPTY, '0, 0,
                                              pssc_pkg::VERDICT_NONE, 1'b1));
      end else begin
        for (i = 0; i < src_total; i++) begin
          pending_results.push_back(make_result(pssc_pkg::KIND_REPORT, known_src[i],
                                                port_total[i],
                                                predict_verdict(port_total[i]),
                                                (i + 1 == src_total)));
        end
      end
    end else begin
      for (i = 0; i < src_total; i++) begin
        if (hit < 0 && known_src[i] == a) hit = i;
      end
      if (hit >= 0) begin
        for (k = 0; k < port_total[hit]; k++) begin
          if (known_port[hit][k] == p) found = 1'b1;
        end
        if (found) begin
          pending_results.push_back(make_result(pssc_pkg::KIND_REPEAT, a, port_total[hit],
                                                predict_verdict(port_total[hit]), 1'b1));
        end else if (port_total[hit] < pssc_pkg::MaxPorts) begin
          known_port[hit][port_total[hit]] = p;
          port_total[hit]++;
          pending_results.push_back(make_result(pssc_pkg::KIND_NEW_PORT, a, port_total[hit],
                                                predict_verdict(port_total[hit]), 1'b1));
        end else begin
          pending_results.push_back(make_result(pssc_pkg::KIND_PORTS_FULL, a,
                                                port_total[hit],
                                                predict_verdict(port_total[hit]), 1'b1));
        end
      end else if (src_total < pssc_pkg::MaxSources) begin
        known_src[src_total]     = a;
        known_port[src_total][0] = p;
        port_total[src_total]    = 1;
        src_total++;
        pending_results.push_back(make_result(pssc_pkg::KIND_NEW_SOURCE, a, 1,
                                              predict_verdict(1), 1'b1));
      end else begin
        pending_results.push_back(make_result(pssc_pkg::KIND_TABLE_FULL, a, 0,
                                              pssc_pkg::VERDICT_NONE, 1'b1));
      end
    end
  endtask

  // send one item and record its expected results
  task automatic send_item(input logic act, input logic [31:0] a, input logic [15:0] p);
    if (!tail_phase && $urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, p, a, act};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict(act, a, p);
    items_sent++;
    s_axis_tvalid <= 1'b0;
  endtask

  // write one threshold once nothing is in flight
  task automatic write_cfg(input logic idx, input logic [6:0] val);
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pssc_pkg::CFG_LIKELY) thr_likely = val;
    else thr_possible = val;
  endtask

  task automatic test_empty_report();
    send_item(pssc_pkg::ACTION_REPORT, $urandom, 16'($urandom));
  endtask

  task automatic test_new_sources();
    send_item(pssc_pkg::ACTION_RECORD, addr_pool[0], 16'd22);
    send_item(pssc_pkg::ACTION_RECORD, addr_pool[1], 16'd80);
    send_item(pssc_pkg::ACTION_RECORD, addr_pool[2], 16'd443);
    send_item(pssc_pkg::ACTION_REPORT, 32'd0, 16'd0);
  endtask

  task automatic test_repeat_ports();
    send_item(pssc_pkg::ACTION_RECORD, addr_pool[1], 16'd80);
    send_item(pssc_pkg::ACTION_RECORD, addr_pool[1], 16'd81);
    send_item(pssc_pkg::ACTION_RECORD, addr_pool[1], 16'd80);
    send_item(pssc_pkg::ACTION_RECORD, addr_pool[1], 16'd81);
    send_item(pssc_pkg::ACTION_RECORD, addr_pool[1], 16'd0);
    send_item(pssc_pkg::ACTION_RECORD, addr_pool[1], 16'hFFFF);
    send_item(pssc_pkg::ACTION_RECORD, addr_pool[2], 16'd443);
    send_item(pssc_pkg::ACTION_RECORD, addr_pool[2], 16'd0);
    send_item(pssc_pkg::ACTION_RECORD, addr_pool[2], 16'd0);
    send_item(pssc_pkg::ACTION_REPORT, 32'd0, 16'd0);
  endtask

  task automatic test_port_saturation();
    int j;
    for (j = 0; j < 65; j++) begin
      send_item(pssc_pkg::ACTION_RECORD, addr_pool[0], 16'(1000 + j));
    end
    send_item(pssc_pkg::ACTION_RECORD, addr_pool[0], 16'd22);
    send_item(pssc_pkg::ACTION_RECORD, addr_pool[0], 16'd1010);
  endtask

  task automatic test_thresholds();
    write_cfg(pssc_pkg::CFG_LIKELY, 7'd64);
    write_cfg(pssc_pkg::CFG_POSSIBLE, 7'd0);
    send_item(pssc_pkg::ACTION_REPORT, 32'd0, 16'd0);
    write_cfg(pssc_pkg::CFG_LIKELY, 7'd100);
    write_cfg(pssc_pkg::CFG_POSSIBLE, 7'd127);
    send_item(pssc_pkg::ACTION_REPORT, 32'd0, 16'd0);
    write_cfg(pssc_pkg::CFG_LIKELY, 7'd20);
    write_cfg(pssc_pkg::CFG_POSSIBLE, 7'd10);
  endtask

  task automatic test_table_full();
    int j;
    for (j = 3; j < 32; j++) begin
      send_item(pssc_pkg::ACTION_RECORD, addr_pool[j], 16'(j));
    end
    send_item(pssc_pkg::ACTION_RECORD, addr_pool[32], 16'd7);
    send_item(pssc_pkg::ACTION_RECORD, addr_pool[33], 16'd8);
    send_item(pssc_pkg::ACTION_REPORT, 32'd0, 16'd0);
  endtask

  task automatic test_random();
    int          pick;
    logic [15:0] p;
    while (items_sent < TotalItems) begin
      if (items_sent >= TotalItems - 40) tail_phase = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_item(pssc_pkg::ACTION_REPORT, $urandom, 16'($urandom));
      end else begin
        if (pick < 7) write_cfg(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
        if ($urandom_range(0, 9) == 0) p = 16'($urandom);
        else p = 16'($urandom_range(0, 79));
        send_item(pssc_pkg::ACTION_RECORD, addr_pool[$urandom_range(0, PoolSize - 1)], p);
      end
    end
  endtask

  // output backpressure
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (tail_phase) m_axis_tready <= 1'b1;
      else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // check each result item
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind    = m_axis_tuser;
      got.src     = m_axis_tdata[31:0];
      got.cnt     = m_axis_tdata[38:32];
      got.verdict = m_axis_tdata[40:39];
      got.last    = m_axis_tlast;
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected result: kind=%0d src=%h cnt=%0d verdict=%0d last=%0d",
                   got.kind, got.src, got.cnt, got.verdict, got.last);
        end
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (mismatch_count < 10) begin
            $display("mismatch: expected kind=%0d src=%h cnt=%0d verdict=%0d last=%0d",
                     want.kind, want.src, want.cnt, want.verdict, want.last);
            $display("          actual   kind=%0d src=%h cnt=%0d verdict=%0d last=%0d",
                     got.kind, got.src, got.cnt, got.verdict, got.last);
          end
          mismatch_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    int j;
    rst            <= 1'b1;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= 1'b0;
    cfg_data       <= '0;
    thr_likely     = 7'd20;
    thr_possible   = 7'd10;
    src_total      = 0;
    mismatch_count = 0;
    items_sent     = 0;
    tail_phase     = 1'b0;
    for (j = 0; j < PoolSize; j++) addr_pool[j] = {8'(j + 1), 24'($urandom)};
    addr_pool[3] = 32'hFFFF_FFFF;
    addr_pool[4] = 32'h0000_0000;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_empty_report();
    test_new_sources();
    test_repeat_ports();
    test_port_saturation();
    test_thresholds();
    test_table_full();
    test_random();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
